// ===== sv/kbv_pkg.sv =====
`timescale 1ns / 1ps
package kbv_pkg;

    localparam int unsigned ROW_DEPTH = 1024;
    localparam int unsigned ADDR_W    = $clog2(ROW_DEPTH);
    localparam int unsigned CAP_W     = 10;
    localparam int unsigned WEIGHT_W  = 10;
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned BEST_W    = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

    // job queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [VALUE_W-1:0]  value;
        logic                last;
        logic [ADDR_W-1:0]   cap;   // effective capacity at accept time
        logic                skip;  // item heavier than capacity
    } t_job;

endpackage

// ===== sv/kbv_if.sv =====
`timescale 1ns / 1ps
interface kbv_in_if import kbv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] item_weight;
    logic [VALUE_W-1:0]  item_value;
    logic                last_item;

    modport source (output valid, output item_weight, output item_value,
                    output last_item, input ready);
    modport sink   (input valid, input item_weight, input item_value,
                    input last_item, output ready);
endinterface

interface kbv_out_if import kbv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BEST_W-1:0] best_value;
    logic              saturated;

    modport source (output valid, output best_value, output saturated, input ready);
    modport sink   (input valid, input best_value, input saturated, output ready);
endinterface

// ===== sv/kbv_front.sv =====
`timescale 1ns / 1ps
module kbv_front import kbv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kbv_in_if.sink           i_item,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_q_full,
    input  logic             i_boot,
    output logic             o_push,
    output t_job             o_job
);

    logic [CAP_W-1:0]  r_capacity;
    logic [ADDR_W-1:0] w_eff_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // clamp capacity to the row
    always_comb begin
        if (32'(r_capacity) > 32'(ROW_DEPTH - 1)) begin
            w_eff_cap = ADDR_W'(ROW_DEPTH - 1);
        end else begin
            w_eff_cap = ADDR_W'(r_capacity);
        end
    end

    assign i_item.ready = !i_q_full && !i_boot;
    assign o_push       = i_item.valid && i_item.ready;

    always_comb begin
        o_job.weight = i_item.item_weight;
        o_job.value  = i_item.item_value;
        o_job.last   = i_item.last_item;
        o_job.cap    = w_eff_cap;
        o_job.skip   = 32'(i_item.item_weight) > 32'(w_eff_cap);
    end

endmodule

// ===== sv/kbv_queue.sv =====
`timescale 1ns / 1ps
module kbv_queue import kbv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = r_count == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_empty   = r_count == '0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/kbv_back.sv =====
`timescale 1ns / 1ps
module kbv_back import kbv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_empty,
    input  t_job     i_q_job,
    output logic     o_pop,
    output logic     o_boot,
    kbv_out_if.source o_result
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SWEEP  = 5'b00010,
        S_FETCH  = 5'b00100,
        S_RESULT = 5'b01000,
        S_CLEAR  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_c, n_c;
    t_job              r_job, n_job;
    logic              r_boot, n_boot;
    logic              r_ovf, n_ovf;
    logic              r_out_vld, n_out_vld;
    logic [BEST_W-1:0] r_out_best, n_out_best;
    logic              r_out_sat, n_out_sat;

    // row memory, read data registered
    logic [BEST_W-1:0] r_mem [ROW_DEPTH];
    logic [BEST_W-1:0] r_rd_hi;
    logic [BEST_W-1:0] r_rd_lo;
    logic              r_s1_vld;
    logic [ADDR_W-1:0] r_s1_addr;

    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr_hi;
    logic [ADDR_W-1:0] w_rd_addr_lo;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [BEST_W-1:0] w_wr_data;
    logic [BEST_W:0]   w_sum;
    logic              w_sat;
    logic [BEST_W-1:0] w_cand;
    logic              w_upd;

    // update stage: candidate = row[c - w] + value, saturating
    assign w_sum  = {1'b0, r_rd_lo} + (BEST_W + 1)'(r_job.value);
    assign w_sat  = w_sum[BEST_W];
    assign w_cand = w_sat ? '1 : w_sum[BEST_W-1:0];
    assign w_upd  = r_s1_vld && (w_cand > r_rd_hi);

    assign w_rd_addr_hi = (r_state == S_SWEEP) ? r_c : r_job.cap;
    assign w_rd_addr_lo = ADDR_W'(32'(r_c) - 32'(r_job.weight));

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_mem_we  = 1'b1;
            w_wr_addr = r_c;
            w_wr_data = '0;
        end else begin
            w_mem_we  = w_upd;
            w_wr_addr = r_s1_addr;
            w_wr_data = w_cand;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_job      = r_job;
        n_boot     = r_boot;
        n_ovf      = r_ovf;
        n_out_vld  = r_out_vld;
        n_out_best = r_out_best;
        n_out_sat  = r_out_sat;
        o_pop      = 1'b0;
        w_rd_en    = 1'b0;

        if (r_s1_vld && w_sat) begin
            n_ovf = 1'b1;
        end
        if (r_out_vld && o_result.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_job = i_q_job;
                    if (!i_q_job.skip) begin
                        n_c     = i_q_job.cap;
                        n_state = S_SWEEP;
                    end else if (i_q_job.last) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_SWEEP: begin
                w_rd_en = 1'b1;
                if (32'(r_c) == 32'(r_job.weight)) begin
                    n_state = r_job.last ? S_FETCH : S_IDLE;
                end else begin
                    n_c = r_c - 1'b1;
                end
            end
            S_FETCH: begin
                // wait for the last row write to land
                if (!r_s1_vld) begin
                    w_rd_en = 1'b1;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_vld || o_result.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_best = r_rd_hi;
                    n_out_sat  = r_ovf;
                    n_ovf      = 1'b0;
                    n_c        = '0;
                    n_state    = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_c == ADDR_W'(ROW_DEPTH - 1)) begin
                    n_boot  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            default: begin
                n_c     = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_hi <= r_mem[w_rd_addr_hi];
            r_rd_lo <= r_mem[w_rd_addr_lo];
        end
        r_s1_addr  <= r_c;
        r_job      <= n_job;
        r_out_best <= n_out_best;
        r_out_sat  <= n_out_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_c       <= '0;
            r_boot    <= 1'b1;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
            r_s1_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_c       <= n_c;
            r_boot    <= n_boot;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
            r_s1_vld  <= w_rd_en && (r_state == S_SWEEP);
        end
    end

    assign o_boot              = r_boot;
    assign o_result.valid      = r_out_vld;
    assign o_result.best_value = r_out_best;
    assign o_result.saturated  = r_out_sat;

    // update stage only follows a sweep read
    a_s1_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> $past(r_state == S_SWEEP))
        else $error("update stage without sweep read");

    // clearing never overlaps a row update
    a_clear_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_s1_vld)
        else $error("row clear overlaps update");

    // sweep stays at or above the item weight
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (32'(r_c) >= 32'(r_job.weight)))
        else $error("sweep below item weight");

    // result fetch is issued once the update stage is empty
    a_fetch_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH && !r_s1_vld) |=> (r_state == S_RESULT))
        else $error("result fetch not issued");

    // no new item is taken while the row is being cleared
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("item taken during clear");

endmodule

// ===== sv/knapsack_01_best_value_core.sv =====
`timescale 1ns / 1ps
// 0-1 knapsack best value, row dynamic program. Items stream in on i_item; each
// one sweeps the stored row of best values from the effective capacity down to
// its weight, one entry per cycle through a 1024 x 32 bit row memory with two
// read ports and one write port; an item heavier than the capacity skips the
// sweep. An item with last_item set returns one result, the best value at full
// capacity plus the saturation flag, after its sweep; the row is then cleared,
// one entry a cycle. After reset the same clearing pass runs with i_item.ready
// held low (capacity writes are taken as usual). A four-entry job queue sits
// between the input and the row engine, so items keep arriving during a sweep or
// a clear until it fills. Capacity writes take effect for items accepted after
// the write.
module knapsack_01_best_value_core import kbv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kbv_in_if.sink           i_item,
    kbv_out_if.source        o_result,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    // front to queue
    logic w_push;
    t_job w_push_job;
    // queue to back
    logic w_q_full;
    logic w_q_empty;
    logic w_pop;
    t_job w_q_job;
    // back busy with the clear after reset
    logic w_boot;

    // accepts items, holds capacity, flags items that do not fit
    kbv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (w_q_full),
        .i_boot      (w_boot),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // decouples acceptance from the row sweep
    kbv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_job   (w_q_job)
    );

    // row memory, sweep, result register and clearing pass
    kbv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_job   (w_q_job),
        .o_pop     (w_pop),
        .o_boot    (w_boot),
        .o_result  (o_result)
    );

endmodule

// ===== sim/tb_knapsack_01_best_value_core.sv =====
`timescale 1ns / 1ps
module tb_knapsack_01_best_value_core;
    import kbv_pkg::*;

    // worst case left in flight after the last result: a full job queue plus
    // the engine, each up to a full-row sweep, and one row clearing pass
    localparam int unsigned SETTLE_CYCLES = 7200;
    // long output stall so the job queue fills and the input backs up
    localparam int unsigned LONG_HOLD     = 4000;
    // zero-weight max-value items stacked in one set
    localparam int unsigned STACK_ITEMS   = 10;
    localparam int unsigned N_PHASES      = 12;
    localparam int unsigned HOLD_PHASE    = 4;

    // expected row contents and the queue of best values still owed
    class knap_scoreboard;
        typedef struct packed {
            logic [BEST_W-1:0] best;
            logic              sat;
        } t_answer;

        logic [BEST_W-1:0] best_row [ROW_DEPTH];
        logic              sum_clamped;
        logic [CAP_W-1:0]  capacity;
        t_answer           answers [$];
        int unsigned       items_seen;
        int unsigned       answers_checked;
        int unsigned       errors;

        function new();
            clear_row();
            capacity        = CAP_RESET;
            items_seen      = 0;
            answers_checked = 0;
            errors          = 0;
        endfunction

        function void clear_row();
            foreach (best_row[i]) best_row[i] = '0;
            sum_clamped = 1'b0;
        endfunction

        // one dp pass over the row, top entry first so each read sees the old row
        function void pack_item(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                                input logic last);
            int unsigned       top;
            int                c;
            logic [BEST_W:0]   sum;
            logic [BEST_W-1:0] cand;
            t_answer           ans;
            top = (capacity > ROW_DEPTH - 1) ? ROW_DEPTH - 1 : capacity;
            items_seen++;
            if (w <= top) begin
                for (c = int'(top); c >= int'(w); c--) begin
                    sum = {1'b0, best_row[c - int'(w)]} + {{(BEST_W + 1 - VALUE_W){1'b0}}, v};
                    if (sum[BEST_W]) begin
                        cand        = '1;
                        sum_clamped = 1'b1;
                    end else begin
                        cand = sum[BEST_W-1:0];
                    end
                    if (cand > best_row[c]) best_row[c] = cand;
                end
            end
            if (last) begin
                ans.best = best_row[top];
                ans.sat  = sum_clamped;
                answers.push_back(ans);
                clear_row();
            end
        endfunction

        function void check_result(input logic [BEST_W-1:0] best, input logic sat);
            t_answer ans;
            if (answers.size() == 0) begin
                $display("%0t: result with nothing expected, best_value %h saturated %b",
                         $time, best, sat);
                errors++;
                return;
            end
            ans = answers.pop_front();
            answers_checked++;
            if (best !== ans.best) begin
                $display("%0t: best_value mismatch, expected %h, actual %h",
                         $time, ans.best, best);
                errors++;
            end
            if (sat !== ans.sat) begin
                $display("%0t: saturated mismatch, expected %b, actual %b",
                         $time, ans.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    kbv_in_if  item_if ();
    kbv_out_if result_if ();

    knap_scoreboard sb = new();

    // idle percentages for the two sides, changed per phase
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    // one-shot request for the long output stall, taken by the result sink
    bit          hold_req       = 1'b0;

    // per-phase capacity and item count; the 1023 phases are kept short
    int unsigned phase_cap   [N_PHASES] = '{23, 63, 1, 40, 3, 1023, 12, 31, 100, 0, 1023, 9};
    int unsigned phase_items [N_PHASES] = '{60, 60, 50, 60, 40, 14, 60, 60, 40, 40, 12, 60};
    // idle modes cycle: none, sender idle, receiver stall, both
    int unsigned mode_src    [4] = '{0, 49, 0, 22};
    int unsigned mode_sink   [4] = '{0, 0, 49, 22};

    knapsack_01_best_value_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // capacity write, only ever called with the block drained
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(posedge i_clk);
        sb.capacity = cap;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // offer one item, with random idle cycles ahead of it, and hold until taken
    task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                             input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge i_clk);
        end
        item_if.valid       = 1'b1;
        item_if.item_weight = w;
        item_if.item_value  = v;
        item_if.last_item   = last;
        do @(posedge i_clk); while (!item_if.ready);
        sb.pack_item(w, v, last);
    endtask

    task automatic send_random_item(input int unsigned top, input bit force_last);
        logic [WEIGHT_W-1:0] w;
        logic [VALUE_W-1:0]  v;
        logic                l;
        int unsigned         pick;
        // mostly weights that fit, some zero, some anywhere in range
        pick = $urandom_range(0, 9);
        if (pick == 0)      w = WEIGHT_W'($urandom_range(0, 1023));
        else if (pick == 1) w = '0;
        else                w = WEIGHT_W'($urandom_range(0, top));
        pick = $urandom_range(0, 9);
        if (pick == 0)      v = '1;
        else if (pick == 1) v = '0;
        else                v = VALUE_W'($urandom_range(0, 65535));
        // wide rows get short sets so the sweeps stay affordable
        l = force_last || ($urandom_range(0, (top >= 512) ? 2 : 5) == 0);
        send_item(w, v, l);
    endtask

    // sender pause: drop valid, wait out every owed result and the tail work
    task automatic settle();
        @(negedge i_clk);
        item_if.valid = 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random or held-off ready, checked at the rising edge
    initial begin : result_sink
        int unsigned hold_left;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                result_if.ready = 1'b0;
                hold_left--;
            end else begin
                result_if.ready = ($urandom_range(0, 99) >= sink_stall_pct);
            end
            @(posedge i_clk);
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.best_value, result_if.saturated);
        end
    end

    initial begin : stimulus
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        item_if.valid       = 1'b0;
        item_if.item_weight = '0;
        item_if.item_value  = '0;
        item_if.last_item   = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // capacity write lands during the post-reset clearing pass
        set_capacity(CAP_W'(1023));
        // heaviest item that still fits the widest row
        send_item(10'd1023, 16'hffff, 1'b1);
        // zero weight counts once per item, then a light item on top
        send_item(10'd0, 16'hffff, 1'b0);
        send_item(10'd0, 16'hffff, 1'b0);
        send_item(10'd1, 16'd1, 1'b1);

        settle();
        set_capacity(CAP_W'(5));
        // one item too heavy, then a small set with a real choice to make
        send_item(10'd6, 16'd100, 1'b0);
        send_item(10'd5, 16'd7, 1'b0);
        send_item(10'd2, 16'd3, 1'b0);
        send_item(10'd3, 16'd4, 1'b1);
        // empty item ending a set
        send_item(10'd0, 16'd0, 1'b1);
        // open a set, then shrink and regrow the capacity inside it
        send_item(10'd2, 16'd10, 1'b0);
        settle();
        set_capacity(CAP_W'(0));
        send_item(10'd0, 16'd1, 1'b0);
        send_item(10'd1, 16'd5, 1'b0);
        settle();
        set_capacity(CAP_W'(5));
        send_item(10'd1, 16'd2, 1'b1);
        settle();
        set_capacity(CAP_W'(0));
        // too heavy for a zero capacity
        send_item(10'd1023, 16'hffff, 1'b1);

        // max-value zero-weight items stacked back to back at zero capacity
        for (int i = 0; i < STACK_ITEMS; i++)
            send_item(10'd0, 16'hffff, (i == STACK_ITEMS - 1));

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            set_capacity(CAP_W'(phase_cap[p]));
            src_idle_pct   = mode_src[p % 4];
            sink_stall_pct = mode_sink[p % 4];
            if (p == HOLD_PHASE) hold_req = 1'b1;
            // odd phases but the last leave a set open across the next capacity write
            for (int k = 0; k < phase_items[p]; k++)
                send_random_item(phase_cap[p],
                                 (k == phase_items[p] - 1) &&
                                 ((p % 2 == 0) || (p == N_PHASES - 1)));
        end

        @(negedge i_clk);
        item_if.valid = 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        // trailing row clear, and time for any stray result to show up
        repeat (2000) @(posedge i_clk);

        $display("covered %0d items and %0d best values over capacities 0 to 1023,",
                 sb.items_seen, sb.answers_checked);
        $display("with stacked zero-weight sets, mid-set capacity changes and a long output stall");
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("TB_ERROR");
        $finish;
    end

endmodule
